[rtl/asgr_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the sgr attribute parser
// no dependencies

package asgr_pkg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ESC  = 2'd1,
        ST_SEQ  = 2'd2
    } parse_state_t;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_RESET = 2'd2
    } kind_t;

    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_LBRK  = 8'h5B;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_M     = 8'h6D;
    localparam logic [7:0] BYTE_DIG0  = 8'h30;
    localparam logic [7:0] BYTE_DIG9  = 8'h39;

    localparam logic [7:0] CODE_RESET = 8'd0;
    localparam logic [7:0] CODE_BOLD  = 8'd1;
    localparam logic [7:0] CODE_UL    = 8'd4;
    localparam logic [7:0] CODE_FG_LO = 8'd30;
    localparam logic [7:0] CODE_FG_HI = 8'd37;
    localparam logic [7:0] CODE_BG_LO = 8'd40;
    localparam logic [7:0] CODE_BG_HI = 8'd47;
    localparam logic [7:0] CODE_MAX   = 8'd255;

    localparam logic [2:0] FG_DEFAULT = 3'd7;
    localparam logic [2:0] BG_DEFAULT = 3'd0;

    // parser context carried from one byte to the next
    typedef struct packed {
        parse_state_t state;
        logic [7:0]   code;
        logic         bold;
        logic         underline;
        logic [2:0]   fg;
        logic [2:0]   bg;
    } parser_ctx_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_out;
        logic       bold_on;
        logic       underline_on;
        logic [2:0] fg_colour;
        logic [2:0] bg_colour;
        logic [6:0] pair_id;
    } result_t;

endpackage

[rtl/asgr_if.sv]
`timescale 1ns / 1ps
// valid/ready channels of the sgr attribute parser: byte beats in, result beats out
// depends on asgr_pkg

interface asgr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       first_of_string;

    modport source (output valid, output char_in, output first_of_string, input ready);
    modport sink   (input valid, input char_in, input first_of_string, output ready);
endinterface

interface asgr_out_if import asgr_pkg::*;;
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] char_out;
    logic       bold_on;
    logic       underline_on;
    logic [2:0] fg_colour;
    logic [2:0] bg_colour;
    logic [6:0] pair_id;

    modport source (output valid, output kind, output char_out, output bold_on,
                    output underline_on, output fg_colour, output bg_colour,
                    output pair_id, input ready);
    modport sink   (input valid, input kind, input char_out, input bold_on,
                    input underline_on, input fg_colour, input bg_colour,
                    input pair_id, output ready);
endinterface

[rtl/asgr_step.sv]
`timescale 1ns / 1ps
// one parser step: next context and optional result for one byte
// depends on asgr_pkg

module asgr_step import asgr_pkg::*;
(
    input  parser_ctx_t ctx,
    input  logic [7:0]  char_in,
    input  logic        first_of_string,
    output parser_ctx_t ctx_next,
    output logic        has_result,
    output result_t     result
);

    parse_state_t st;
    logic [11:0]  acc_wide;
    logic         is_term;

    always_comb
    begin
        ctx_next   = ctx;
        has_result = 1'b0;
        result     = '0;
        st         = first_of_string ? ST_IDLE : ctx.state;
        is_term    = (char_in == BYTE_SEMI) || (char_in == BYTE_M);
        // code * 10 + digit
        acc_wide   = {1'b0, ctx.code, 3'b000} + {3'b000, ctx.code, 1'b0}
                   + {4'b0000, char_in - BYTE_DIG0};

        case (st)
            ST_ESC:
            begin
                if (char_in == BYTE_LBRK)
                begin
                    ctx_next.bold      = 1'b0;
                    ctx_next.underline = 1'b0;
                    ctx_next.fg        = FG_DEFAULT;
                    ctx_next.bg        = BG_DEFAULT;
                    ctx_next.code      = '0;
                    ctx_next.state     = ST_SEQ;
                end
                else
                begin
                    ctx_next.state  = ST_IDLE;
                    has_result      = 1'b1;
                    result.kind     = KIND_CHAR;
                    result.char_out = char_in;
                end
            end
            ST_SEQ:
            begin
                if (is_term)
                begin
                    if (ctx.code == CODE_BOLD)
                        ctx_next.bold = 1'b1;
                    else if (ctx.code == CODE_UL)
                        ctx_next.underline = 1'b1;
                    else if (ctx.code inside {[CODE_FG_LO:CODE_FG_HI]})
                        ctx_next.fg = 3'(ctx.code - CODE_FG_LO);
                    else if (ctx.code inside {[CODE_BG_LO:CODE_BG_HI]})
                        ctx_next.bg = 3'(ctx.code - CODE_BG_LO);
                end

                if (is_term && ctx.code == CODE_RESET)
                begin
                    ctx_next.state = ST_IDLE;
                    has_result     = 1'b1;
                    result.kind    = KIND_RESET;
                end
                else if (char_in == BYTE_M)
                begin
                    ctx_next.state      = ST_IDLE;
                    has_result          = 1'b1;
                    result.kind         = KIND_SET;
                    result.bold_on      = ctx_next.bold;
                    result.underline_on = ctx_next.underline;
                    result.fg_colour    = ctx_next.fg;
                    result.bg_colour    = ctx_next.bg;
                    result.pair_id      = {1'b0, ctx_next.fg, ctx_next.bg} + 7'd1;
                end
                else if (char_in inside {[BYTE_DIG0:BYTE_DIG9]})
                begin
                    ctx_next.code = (acc_wide > {4'b0000, CODE_MAX}) ? CODE_MAX
                                                                     : acc_wide[7:0];
                end
                else if (char_in == BYTE_SEMI)
                begin
                    ctx_next.code = '0;
                end
                else
                begin
                    ctx_next.state  = ST_IDLE;
                    has_result      = 1'b1;
                    result.kind     = KIND_CHAR;
                    result.char_out = char_in;
                end
            end
            default:
            begin
                // idle, and the unused state code
                if (char_in == BYTE_ESC)
                begin
                    ctx_next.state = ST_ESC;
                end
                else
                begin
                    ctx_next.state  = ST_IDLE;
                    has_result      = 1'b1;
                    result.kind     = KIND_CHAR;
                    result.char_out = char_in;
                end
            end
        endcase
    end

endmodule

[rtl/ansi_sgr_attribute_parser_unit.sv]
`timescale 1ns / 1ps
// top level of the sgr attribute parser: input register, parser context, result register
// depends on asgr_pkg, asgr_if, asgr_step

// The parser takes one text byte per beat and gives at most one result beat per byte:
// a plain character, an attribute set (bold, underline, colours and colour pair id)
// or an attribute reset. Escape bytes and the codes of an ESC '[' ... 'm' sequence
// produce no beat of their own. A byte beat is registered on entry; when the result
// register is free or being read, a single pass of parser logic updates the context
// and loads the result register. Throughput is one byte per clock while results are
// read; the input register and the result register together decouple the two sides,
// so a byte can still enter an empty input register while a result waits to be read.

module ansi_sgr_attribute_parser_unit import asgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    asgr_in_if.sink     items,
    asgr_out_if.source  results
);

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_first_reg;

    // parser context
    parser_ctx_t ctx_reg;
    parser_ctx_t ctx_next;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;

    logic        step_has_result;
    result_t     step_result;
    logic        advance;

    // the input stage moves on whenever the result register is free or being read
    assign advance     = !out_valid_reg || results.ready;
    assign items.ready = !in_valid_reg || advance;

    asgr_step u_step
    (
        .ctx             (ctx_reg),
        .char_in         (in_char_reg),
        .first_of_string (in_first_reg),
        .ctx_next        (ctx_next),
        .has_result      (step_has_result),
        .result          (step_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg && step_has_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            ctx_reg.state     <= ST_IDLE;
            ctx_reg.code      <= '0;
            ctx_reg.bold      <= 1'b0;
            ctx_reg.underline <= 1'b0;
            ctx_reg.fg        <= FG_DEFAULT;
            ctx_reg.bg        <= BG_DEFAULT;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (items.ready)
                in_valid_reg <= items.valid;
            // context moves once per byte, when the byte leaves the input stage
            if (in_valid_reg && advance)
                ctx_reg <= ctx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            in_char_reg  <= items.char_in;
            in_first_reg <= items.first_of_string;
        end
        if (advance && in_valid_reg && step_has_result)
            out_reg <= step_result;
    end

    assign results.valid        = out_valid_reg;
    assign results.kind         = out_reg.kind;
    assign results.char_out     = out_reg.char_out;
    assign results.bold_on      = out_reg.bold_on;
    assign results.underline_on = out_reg.underline_on;
    assign results.fg_colour    = out_reg.fg_colour;
    assign results.bg_colour    = out_reg.bg_colour;
    assign results.pair_id      = out_reg.pair_id;

endmodule
